@@ rtl/tbm_pkg.sv @@
// Shared types and constants of the time bucket min/max block.
// No dependencies; every other file uses these by scoped name or by import.
package tbm_pkg;

	localparam int TIME_BITS = 64;
	localparam int MANT_BITS = 48;
	localparam int EXP_BITS = 5;
	localparam int EXP_LIMIT = 12;
	localparam int SCALE_CNT_BITS = 5;
	localparam int DIV_CNT_BITS = 6;

	localparam logic signed [EXP_BITS-1:0] EXP_MAX = EXP_BITS'(EXP_LIMIT);
	localparam logic signed [EXP_BITS-1:0] EXP_MIN = -EXP_MAX;

	typedef enum logic [1:0] {
		CFG_WINDOW_START = 2'd0,
		CFG_WINDOW_END   = 2'd1,
		CFG_BUCKET_WIDTH = 2'd2,
		CFG_ENABLE       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [TIME_BITS-1:0] window_start;
		logic [TIME_BITS-1:0] window_end;
		logic [TIME_BITS-1:0] bucket_width;
		logic                 enable;
	} cfg_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]       t;
		logic [MANT_BITS-1:0]       m;
		logic signed [EXP_BITS-1:0] e;
		logic                       in_win;
		logic                       last;
	} item_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]       bucket_time;
		logic [MANT_BITS-1:0]       low_m;
		logic signed [EXP_BITS-1:0] low_e;
		logic [MANT_BITS-1:0]       high_m;
		logic signed [EXP_BITS-1:0] high_e;
		logic                       run_end;
	} result_t;

endpackage

@@ rtl/tbm_front.sv @@
// Front end: clamps the exponent, tags window membership, drops trades while
// disabled, and holds accepted trades in a two-entry queue. Uses tbm_pkg.
module tbm_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [tbm_pkg::TIME_BITS-1:0]       trade_time,
	input  logic [tbm_pkg::MANT_BITS-1:0]       price_mantissa,
	input  logic signed [tbm_pkg::EXP_BITS-1:0] price_exp,
	input  logic                                final_trade,
	input  tbm_pkg::cfg_t                       cfg,
	output logic                                item_valid,
	output tbm_pkg::item_t                      item,
	input  logic                                item_pop
);

	tbm_pkg::item_t mem_q [2];
	tbm_pkg::item_t cls;
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic wr, rd;

	always_comb begin
		cls.t = trade_time;
		cls.m = price_mantissa;
		if (price_exp > tbm_pkg::EXP_MAX) begin
			cls.e = tbm_pkg::EXP_MAX;
		end else if (price_exp < tbm_pkg::EXP_MIN) begin
			cls.e = tbm_pkg::EXP_MIN;
		end else begin
			cls.e = price_exp;
		end
		cls.in_win = (trade_time >= cfg.window_start) && (trade_time < cfg.window_end);
		cls.last = final_trade;
	end

	assign full = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item = mem_q[rp_q];
	// drop the beat entirely while disabled
	assign wr = push && !full && cfg.enable;
	assign rd = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			if (wr && !rd) cnt_q <= cnt_q + 2'd1;
			else if (rd && !wr) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

@@ rtl/tbm_scale.sv @@
// Exact decimal price compare: scales the operand with the larger exponent
// by ten once per cycle, saturating past the mantissa range. Uses tbm_pkg.
module tbm_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [tbm_pkg::MANT_BITS-1:0]       new_m,
	input  logic signed [tbm_pkg::EXP_BITS-1:0] new_e,
	input  logic [tbm_pkg::MANT_BITS-1:0]       old_m,
	input  logic signed [tbm_pkg::EXP_BITS-1:0] old_e,
	output logic                                done,
	output logic                                lt,
	output logic                                gt
);

	localparam int PROD_BITS = tbm_pkg::MANT_BITS + 4;

	logic [tbm_pkg::MANT_BITS-1:0] sv_q, ov_q;
	logic [tbm_pkg::SCALE_CNT_BITS-1:0] cnt_q;
	logic scale_new_q, sat_q;
	logic signed [tbm_pkg::EXP_BITS:0] diff;
	logic [tbm_pkg::EXP_BITS:0] mag;
	logic [PROD_BITS-1:0] x10;

	assign diff = {new_e[tbm_pkg::EXP_BITS-1], new_e} - {old_e[tbm_pkg::EXP_BITS-1], old_e};
	assign mag = diff[tbm_pkg::EXP_BITS] ? -diff : diff;
	assign x10 = {1'b0, sv_q, 3'b000} + {3'b000, sv_q, 1'b0};
	assign done = (cnt_q == '0);

	always_comb begin
		if (scale_new_q) begin
			lt = !sat_q && (sv_q < ov_q);
			gt = sat_q || (sv_q > ov_q);
		end else begin
			lt = sat_q || (ov_q < sv_q);
			gt = !sat_q && (ov_q > sv_q);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sv_q <= diff[tbm_pkg::EXP_BITS] ? old_m : new_m;
			ov_q <= diff[tbm_pkg::EXP_BITS] ? new_m : old_m;
			scale_new_q <= !diff[tbm_pkg::EXP_BITS];
		end else if (!done && !sat_q && x10[PROD_BITS-1:tbm_pkg::MANT_BITS] == '0) begin
			sv_q <= x10[tbm_pkg::MANT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sat_q <= 1'b0;
		end else if (start) begin
			cnt_q <= mag[tbm_pkg::SCALE_CNT_BITS-1:0];
			sat_q <= 1'b0;
		end else if (!done) begin
			cnt_q <= cnt_q - 1'b1;
			if (x10[PROD_BITS-1:tbm_pkg::MANT_BITS] != '0) sat_q <= 1'b1;
		end
	end

endmodule

@@ rtl/tbm_back.sv @@
// Back end: bucket state, bucket start division, min/max update and result
// emission. Uses tbm_pkg and two tbm_scale units.
module tbm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  tbm_pkg::cfg_t    cfg,
	input  logic             item_valid,
	input  tbm_pkg::item_t   item,
	output logic             item_pop,
	input  logic             res_full,
	output logic             res_push,
	output tbm_pkg::result_t res_data
);

	typedef enum logic [2:0] {S_IDLE, S_CLOSE, S_DIV, S_CMPGO, S_CMP, S_FINAL} state_t;

	state_t state_q;
	tbm_pkg::item_t item_q;
	logic open_q;
	logic [tbm_pkg::TIME_BITS-1:0] start_q;
	logic [tbm_pkg::MANT_BITS-1:0] low_m_q, high_m_q;
	logic signed [tbm_pkg::EXP_BITS-1:0] low_e_q, high_e_q;
	logic [tbm_pkg::TIME_BITS-1:0] dvd_q, rem_q;
	logic [tbm_pkg::DIV_CNT_BITS-1:0] dcnt_q;

	logic [tbm_pkg::TIME_BITS-1:0] w, head_d, q_d;
	logic [tbm_pkg::TIME_BITS:0] trial, trial_sub;
	logic [tbm_pkg::TIME_BITS-1:0] rem_nxt;
	logic close;
	logic cmp_start, lo_done, hi_done, lo_lt, lo_gt, hi_lt, hi_gt;

	assign w = (cfg.bucket_width == '0) ? tbm_pkg::TIME_BITS'(1) : cfg.bucket_width;
	assign close = open_q && (item.t >= start_q) && ((item.t - start_q) >= w);
	assign head_d = item.t - cfg.window_start;
	assign q_d = item_q.t - cfg.window_start;

	// one restoring step of the remainder per cycle
	assign trial = {rem_q, dvd_q[tbm_pkg::TIME_BITS-1]};
	assign trial_sub = trial - {1'b0, w};
	assign rem_nxt = trial_sub[tbm_pkg::TIME_BITS] ? trial[tbm_pkg::TIME_BITS-1:0]
	                                               : trial_sub[tbm_pkg::TIME_BITS-1:0];

	assign item_pop = (state_q == S_IDLE) && item_valid;
	assign cmp_start = (state_q == S_CMPGO);

	always_comb begin
		res_data.bucket_time = start_q;
		res_data.low_m = low_m_q;
		res_data.low_e = low_e_q;
		res_data.high_m = high_m_q;
		res_data.high_e = high_e_q;
		res_data.run_end = (state_q == S_FINAL) || !(item_q.last && item_q.m != '0);
	end
	assign res_push = ((state_q == S_CLOSE) || (state_q == S_FINAL)) &&
	                  (low_m_q != '0) && !res_full;

	tbm_scale u_lo (
		.clk(clk), .arst_n(arst_n), .start(cmp_start),
		.new_m(item_q.m), .new_e(item_q.e), .old_m(low_m_q), .old_e(low_e_q),
		.done(lo_done), .lt(lo_lt), .gt(lo_gt)
	);

	tbm_scale u_hi (
		.clk(clk), .arst_n(arst_n), .start(cmp_start),
		.new_m(item_q.m), .new_e(item_q.e), .old_m(high_m_q), .old_e(high_e_q),
		.done(hi_done), .lt(hi_lt), .gt(hi_gt)
	);

	always_ff @(posedge clk) begin
		if (item_pop) item_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			open_q <= 1'b0;
			start_q <= '0;
			low_m_q <= '0;
			low_e_q <= '0;
			high_m_q <= '0;
			high_e_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			dcnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if (item.in_win) begin
							if (close) begin
								state_q <= S_CLOSE;
							end else if (!open_q) begin
								dvd_q <= head_d;
								rem_q <= '0;
								dcnt_q <= '1;
								state_q <= S_DIV;
							end else begin
								state_q <= S_CMPGO;
							end
						end else if (item.last && open_q) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_CLOSE: begin
					if (low_m_q == '0 || !res_full) begin
						open_q <= 1'b0;
						dvd_q <= q_d;
						rem_q <= '0;
						dcnt_q <= '1;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					rem_q <= rem_nxt;
					dvd_q <= {dvd_q[tbm_pkg::TIME_BITS-2:0], 1'b0};
					dcnt_q <= dcnt_q - 1'b1;
					if (dcnt_q == '0) begin
						start_q <= cfg.window_start + (q_d - rem_nxt);
						open_q <= 1'b1;
						low_m_q <= item_q.m;
						low_e_q <= item_q.e;
						high_m_q <= item_q.m;
						high_e_q <= (item_q.m != '0) ? item_q.e : '0;
						state_q <= item_q.last ? S_FINAL : S_IDLE;
					end
				end
				S_CMPGO: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (lo_done && hi_done) begin
						if (lo_lt) begin
							low_m_q <= item_q.m;
							low_e_q <= item_q.e;
						end
						if (hi_gt) begin
							high_m_q <= item_q.m;
							high_e_q <= item_q.e;
						end
						state_q <= item_q.last ? S_FINAL : S_IDLE;
					end
				end
				S_FINAL: begin
					if (low_m_q == '0 || !res_full) begin
						open_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/tbm_resq.sv @@
// Two-entry result queue in front of the output ports. Uses tbm_pkg.
// Holds up to both results that one trade can produce.
module tbm_resq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  tbm_pkg::result_t wdata,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output tbm_pkg::result_t rdata
);

	tbm_pkg::result_t mem_q [2];
	logic [1:0] cnt_q;
	logic wp_q, rp_q;
	logic rd;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];
	assign rd = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			wp_q <= 1'b0;
			rp_q <= 1'b0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			if (wr && !rd) cnt_q <= cnt_q + 2'd1;
			else if (rd && !wr) cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

@@ rtl/time_bucket_min_max.sv @@
// Top level of the time bucket min/max block: configuration registers,
// front queue, back end and result queue. Uses tbm_pkg and the tbm_* RTL modules.
//
// Trades enter as a queue: a beat is taken when push is high and full low.
// Results leave as a queue: while empty is low the oldest result is on the
// result ports, and it is taken when pop is high. Configuration is a
// valid/ready write port (ready always high), index 0..3 selects window_start,
// window_end, bucket_width, minmax_enable; write only while idle.
// A two-entry queue sits between the front and back ends, and a two-entry
// queue holds results, so trades keep entering while results wait.
// The back end takes one trade at a time. A trade joining the open bucket
// passes S_CMPGO and S_CMP, whose compares scale by ten once per decade of the
// larger exponent gap to the stored low and high (up to 24); a trade opening a
// bucket runs the bucket start division, a one-bit-per-cycle remainder over 64
// bits, after S_CLOSE if it also closes one; a trade outside the window is
// popped in S_IDLE; a final trade that flushes also passes S_FINAL. Results
// wait in the queue that drives the ports. If pop stays low the result queue
// fills, the back end stops, then the front queue fills and full rises.
// Reset clears both queues and the open bucket; configuration returns to
// window 0..0, bucket width 1, enable set.
module time_bucket_min_max (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [tbm_pkg::TIME_BITS-1:0]       trade_time,
	input  logic [tbm_pkg::MANT_BITS-1:0]       price_mantissa,
	input  logic signed [tbm_pkg::EXP_BITS-1:0] price_exp,
	input  logic                                final_trade,
	output logic                                empty,
	input  logic                                pop,
	output logic [tbm_pkg::TIME_BITS-1:0]       bucket_time,
	output logic [tbm_pkg::MANT_BITS-1:0]       low_mantissa,
	output logic signed [tbm_pkg::EXP_BITS-1:0] low_exponent,
	output logic [tbm_pkg::MANT_BITS-1:0]       high_mantissa,
	output logic signed [tbm_pkg::EXP_BITS-1:0] high_exponent,
	output logic                                run_end,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [tbm_pkg::TIME_BITS-1:0]       cfg_data
);

	tbm_pkg::cfg_t cfg_q;
	tbm_pkg::item_t item;
	tbm_pkg::result_t res_w, res_r;
	logic item_valid, item_pop, res_full, res_push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_start <= '0;
			cfg_q.window_end <= '0;
			cfg_q.bucket_width <= tbm_pkg::TIME_BITS'(1);
			cfg_q.enable <= 1'b1;
		end else if (cfg_valid) begin
			case (tbm_pkg::cfg_idx_t'(cfg_index))
				tbm_pkg::CFG_WINDOW_START: cfg_q.window_start <= cfg_data;
				tbm_pkg::CFG_WINDOW_END:   cfg_q.window_end <= cfg_data;
				tbm_pkg::CFG_BUCKET_WIDTH: cfg_q.bucket_width <= cfg_data;
				tbm_pkg::CFG_ENABLE:       cfg_q.enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tbm_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.trade_time(trade_time), .price_mantissa(price_mantissa),
		.price_exp(price_exp), .final_trade(final_trade),
		.cfg(cfg_q), .item_valid(item_valid), .item(item), .item_pop(item_pop)
	);

	tbm_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .item_valid(item_valid),
		.item(item), .item_pop(item_pop), .res_full(res_full),
		.res_push(res_push), .res_data(res_w)
	);

	tbm_resq u_resq (
		.clk(clk), .arst_n(arst_n), .wr(res_push), .wdata(res_w),
		.full(res_full), .empty(empty), .pop(pop), .rdata(res_r)
	);

	assign bucket_time = res_r.bucket_time;
	assign low_mantissa = res_r.low_m;
	assign low_exponent = res_r.low_e;
	assign high_mantissa = res_r.high_m;
	assign high_exponent = res_r.high_e;
	assign run_end = res_r.run_end;

endmodule

@@ sim/tbm_checker.sv @@
// Checker for time_bucket_min_max: watches trade, result and config beats,
// predicts the bucket results and compares them. Depends on tbm_pkg only.
module tbm_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  logic                                full,
	input  logic [tbm_pkg::TIME_BITS-1:0]       trade_time,
	input  logic [tbm_pkg::MANT_BITS-1:0]       price_mantissa,
	input  logic signed [tbm_pkg::EXP_BITS-1:0] price_exp,
	input  logic                                final_trade,
	input  logic                                empty,
	input  logic                                pop,
	input  logic [tbm_pkg::TIME_BITS-1:0]       bucket_time,
	input  logic [tbm_pkg::MANT_BITS-1:0]       low_mantissa,
	input  logic signed [tbm_pkg::EXP_BITS-1:0] low_exponent,
	input  logic [tbm_pkg::MANT_BITS-1:0]       high_mantissa,
	input  logic signed [tbm_pkg::EXP_BITS-1:0] high_exponent,
	input  logic                                run_end,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [tbm_pkg::TIME_BITS-1:0]       cfg_data,
	output int                                  pending,
	output int                                  errors
);
	import tbm_pkg::*;

	longint unsigned win_lo, win_hi, width;
	bit              enabled;
	longint unsigned cur_start;
	bit              is_open;
	longint unsigned lo_m, hi_m;
	int              lo_e, hi_e;
	result_t         bucket_q[$];
	longint unsigned dec_pow[20];

	initial begin
		dec_pow[0] = 1;
		for (int i = 1; i < 20; i++)
			dec_pow[i] = dec_pow[i-1] * 10;
	end

	// sign of ma*10^ea - mb*10^eb, with ea >= eb
	function automatic int scaled_sign(longint unsigned ma, int ea, longint unsigned mb, int eb);
		longint unsigned q, r;
		int d;
		d = ea - eb;
		if (ma == 0)
			return (mb == 0) ? 0 : -1;
		if (d > 19)
			return 1;
		q = mb / dec_pow[d];
		r = mb % dec_pow[d];
		if (ma > q)
			return 1;
		if (ma < q)
			return -1;
		return (r == 0) ? 0 : -1;
	endfunction

	function automatic int price_order(longint unsigned ma, int ea, longint unsigned mb, int eb);
		if (ma == 0 && mb == 0)
			return 0;
		if (ea >= eb)
			return scaled_sign(ma, ea, mb, eb);
		return -scaled_sign(mb, eb, ma, ea);
	endfunction

	function automatic void close_bucket(ref int produced);
		result_t r;
		if (lo_m == 0)
			return;
		r.bucket_time = cur_start;
		r.low_m = lo_m[MANT_BITS-1:0];
		r.low_e = EXP_BITS'(lo_e);
		r.high_m = hi_m[MANT_BITS-1:0];
		r.high_e = EXP_BITS'(hi_e);
		r.run_end = 1'b0;
		bucket_q = {bucket_q, r};
		produced++;
	endfunction

	function automatic void predict_trade(longint unsigned t, longint unsigned m, int e, bit last);
		longint unsigned w, d;
		int produced;
		produced = 0;
		w = (width == 0) ? 1 : width;
		if (!enabled)
			return;
		if (e > EXP_LIMIT)
			e = EXP_LIMIT;
		if (e < -EXP_LIMIT)
			e = -EXP_LIMIT;
		if (t >= win_lo && t < win_hi) begin
			if (is_open && t >= cur_start && t - cur_start >= w) begin
				close_bucket(produced);
				is_open = 0;
			end
			if (!is_open) begin
				d = t - win_lo;
				cur_start = win_lo + (d - d % w);
				is_open = 1;
				lo_m = m;
				lo_e = e;
				hi_m = 0;
				hi_e = 0;
			end else if (price_order(m, e, lo_m, lo_e) < 0) begin
				lo_m = m;
				lo_e = e;
			end
			if (price_order(m, e, hi_m, hi_e) > 0) begin
				hi_m = m;
				hi_e = e;
			end
		end
		if (last && is_open) begin
			close_bucket(produced);
			is_open = 0;
		end
		if (produced > 0)
			bucket_q[$].run_end = 1'b1;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			win_lo = 0;
			win_hi = 0;
			width = 1;
			enabled = 1;
			cur_start = 0;
			is_open = 0;
			lo_m = 0;
			lo_e = 0;
			hi_m = 0;
			hi_e = 0;
			bucket_q.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_WINDOW_START: win_lo = cfg_data;
					CFG_WINDOW_END:   win_hi = cfg_data;
					CFG_BUCKET_WIDTH: width = cfg_data;
					CFG_ENABLE:       enabled = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full)
				predict_trade(trade_time, price_mantissa, int'(price_exp), final_trade);
			if (pop && !empty) begin
				if (bucket_q.size() == 0) begin
					report("unexpected beat", bucket_time, 0);
				end else begin
					w = bucket_q.pop_front();
					if (bucket_time !== w.bucket_time)
						report("bucket_time", bucket_time, w.bucket_time);
					if (low_mantissa !== w.low_m)
						report("low_mantissa", low_mantissa, w.low_m);
					if (low_exponent !== w.low_e)
						report("low_exponent", low_exponent, w.low_e);
					if (high_mantissa !== w.high_m)
						report("high_mantissa", high_mantissa, w.high_m);
					if (high_exponent !== w.high_e)
						report("high_exponent", high_exponent, w.high_e);
					if (run_end !== w.run_end)
						report("run_end", run_end, w.run_end);
				end
			end
		end
		pending = bucket_q.size();
	end

endmodule

@@ sim/tb.sv @@
// Top of the time_bucket_min_max testbench: clock, reset, trade and config
// stimulus, result drain and verdict. Uses tbm_pkg, the DUT and tbm_checker.
module tb;
	import tbm_pkg::*;

	localparam longint unsigned TMAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam longint unsigned MMAX = 48'hFFFF_FFFF_FFFF;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int DRAIN_CYCLES = 400;

	logic                       clk = 0;
	logic                       arst_n = 0;
	logic                       push = 0;
	logic                       full;
	logic [TIME_BITS-1:0]       trade_time = '0;
	logic [MANT_BITS-1:0]       price_mantissa = '0;
	logic signed [EXP_BITS-1:0] price_exp = '0;
	logic                       final_trade = 0;
	logic                       empty;
	logic                       pop = 0;
	logic [TIME_BITS-1:0]       bucket_time;
	logic [MANT_BITS-1:0]       low_mantissa;
	logic signed [EXP_BITS-1:0] low_exponent;
	logic [MANT_BITS-1:0]       high_mantissa;
	logic signed [EXP_BITS-1:0] high_exponent;
	logic                       run_end;
	logic                       cfg_valid = 0;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index = '0;
	logic [TIME_BITS-1:0]       cfg_data = '0;
	int                         pending, errors;
	int                         cycles = 0;
	bit                         steady = 0;
	longint unsigned            cur_width = 1;

	always #5 clk = ~clk;

	time_bucket_min_max u_dut (.*);

	tbm_checker u_chk (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// stall the result side now and then
	always @(posedge clk) begin
		int n;
		n = idle_len();
		if (n == 0) begin
			pop <= 1'b1;
		end else begin
			pop <= 1'b0;
			repeat (n) @(posedge clk);
			pop <= 1'b1;
		end
	end

	function automatic longint unsigned rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_trade(longint unsigned t, longint unsigned m, int e, bit last);
		int gap;
		trade_time <= t;
		price_mantissa <= m[MANT_BITS-1:0];
		price_exp <= e[EXP_BITS-1:0];
		final_trade <= last;
		push <= 1'b1;
		do @(posedge clk); while (full);
		gap = idle_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(cfg_idx_t idx, longint unsigned v);
		cfg_index <= idx;
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_window(longint unsigned lo, longint unsigned hi, longint unsigned w,
			bit en);
		settle();
		write_reg(CFG_WINDOW_START, lo);
		write_reg(CFG_WINDOW_END, hi);
		write_reg(CFG_BUCKET_WIDTH, w);
		write_reg(CFG_ENABLE, en);
		cur_width = (w == 0) ? 1 : w;
	endtask

	function automatic longint unsigned pick_mantissa();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4)
			return 0;
		if (r < 8)
			return MMAX;
		if (r < 60)
			return $urandom_range(1, 5000);
		return rand64() & MMAX;
	endfunction

	function automatic int pick_exponent();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 31);
		return $urandom_range(0, 24) - 12;
	endfunction

	// random trade sets with time moving forward at the scale of the bucket width
	task automatic random_trades(int count, longint unsigned lo);
		longint unsigned t, step, nxt;
		int r;
		t = (lo > 50) ? lo - $urandom_range(0, 50) : 0;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				step = rand64() % (cur_width / 3 + 1);
			else if (r < 90)
				step = (cur_width > 64'h3FFF_FFFF_FFFF_FFFF) ? rand64() % cur_width
					: rand64() % (cur_width * 2 + 1);
			else if (r < 97)
				step = rand64() >> $urandom_range(0, 63);
			else
				step = 0;
			nxt = t + step;
			t = (nxt < t) ? TMAX : nxt;
			if ($urandom_range(0, 49) == 0)
				t = t - (t % 7); // occasional step back in time
			send_trade(t, pick_mantissa(), pick_exponent(), ($urandom_range(0, 19) == 0));
			if (t == TMAX)
				t = lo;
		end
		send_trade(t, pick_mantissa(), pick_exponent(), 1'b1);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window is empty: nothing joins, nothing comes out
		send_trade(0, 5, 0, 1'b0);
		send_trade(10, 7, 1, 1'b1);

		set_window(1000, 1000000, 100, 1'b1);
		send_trade(500, 3, 0, 1'b0);
		send_trade(1000, 5, 0, 1'b0);
		send_trade(1010, 50, -1, 1'b0);
		send_trade(1020, MMAX, 12, 1'b0);
		send_trade(1030, 1, -16, 1'b0);
		send_trade(1040, 3, 15, 1'b0);
		send_trade(1005, 2, -12, 1'b0);
		send_trade(1350, 7, 2, 1'b0);
		send_trade(1399, 70, 1, 1'b0);
		send_trade(1600, 9, 0, 1'b1);
		send_trade(1700, 0, 0, 1'b0);
		send_trade(1710, 4, 3, 1'b0);
		send_trade(1900, 2, -3, 1'b0);
		send_trade(1950, MMAX, -12, 1'b0);
		send_trade(2000000, 1, 0, 1'b1);
		send_trade(5000, 1, 12, 1'b1);
		send_trade(999999, MMAX, 0, 1'b0);
		send_trade(1000000, 8, 0, 1'b1);

		set_window(0, TMAX, 0, 1'b1);
		send_trade(0, 1, 0, 1'b0);
		send_trade(0, 2, 0, 1'b0);
		send_trade(TMAX - 1, MMAX, -12, 1'b1);

		set_window(1000, 2000, 10, 1'b0);
		send_trade(1000, 5, 0, 1'b0);
		send_trade(1500, 6, 0, 1'b1);

		set_window(5, TMAX, TMAX, 1'b1);
		random_trades(60, 5);

		set_window(0, TMAX, 1, 1'b1);
		random_trades(80, 0);

		for (int p = 0; p < 8; p++) begin
			longint unsigned lo, w;
			lo = rand64() >> $urandom_range(1, 63);
			w = ($urandom_range(0, 3) == 0) ? rand64() >> $urandom_range(2, 63)
				: $urandom_range(0, 500);
			steady = (p % 3 == 2);
			set_window(lo, lo + ((w == 0 ? 1 : w) * $urandom_range(20, 60)), w,
				($urandom_range(0, 7) != 0));
			random_trades(65, lo);
		end
		steady = 0;

		set_window(0, TMAX, TMAX, 1'b1);
		random_trades(20, 0);

		settle();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
